[rtl/i2cmbe_pkg.sv]
`default_nettype none

package i2cmbe_pkg;

    // Input opcodes
    typedef enum logic [2:0] {
        OP_START  = 3'd0,
        OP_STOP   = 3'd1,
        OP_WR_CHK = 3'd2,
        OP_WR     = 3'd3,
        OP_RD     = 3'd4,
        OP_ACK    = 3'd5,
        OP_NACK   = 3'd6,
        OP_TICK   = 3'd7
    } t_op;

    // Active command, opcode plus one; zero is idle
    typedef enum logic [2:0] {
        CMD_IDLE   = 3'd0,
        CMD_START  = 3'd1,
        CMD_STOP   = 3'd2,
        CMD_WR_CHK = 3'd3,
        CMD_WR     = 3'd4,
        CMD_RD     = 3'd5,
        CMD_ACK    = 3'd6,
        CMD_NACK   = 3'd7
    } t_cmd;

    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_PHASE_TICKS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT = 1'd1;

    localparam logic [7:0]  PHASE_TICKS_RST = 8'd10;
    localparam logic [15:0] ACK_TIMEOUT_RST = 16'd100;

    // Write sequence phases
    localparam logic [4:0] PH_ACK_LOW  = 5'd16;
    localparam logic [4:0] PH_ACK_POLL = 5'd18;
    localparam logic [4:0] PH_ACK_END  = 5'd19;
    localparam logic [4:0] PH_AUTO_STP = 5'd20;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] wr_data;
        logic       sda_in;
    } t_in_item;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rd_data;
        logic       ack_fail;
        logic       cmd_rejected;
    } t_out_item;

    typedef struct packed {
        logic scl;
        logic sda;
        logic drv;
    } t_lines;

endpackage

`default_nettype wire

[rtl/i2cmbe_in_reg.sv]
`default_nettype none

module i2cmbe_in_reg (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  i2cmbe_pkg::t_in_item  i_in_data,
    input  wire                   i_advance,
    output logic                  o_valid,
    output i2cmbe_pkg::t_in_item  o_data
);
    import i2cmbe_pkg::*;

    logic     r_valid;
    t_in_item r_data;

    assign o_in_ready = !r_valid || i_advance;
    assign o_valid    = r_valid;
    assign o_data     = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_data <= i_in_data;
        end
    end

endmodule

`default_nettype wire

[rtl/i2cmbe_core.sv]
`default_nettype none

module i2cmbe_core (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire [i2cmbe_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire [i2cmbe_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  wire                                i_step,
    input  i2cmbe_pkg::t_in_item               i_item,
    output i2cmbe_pkg::t_out_item              o_result
);
    import i2cmbe_pkg::*;

    typedef struct packed {
        logic   ok;
        t_lines lines;
    } t_phase_out;

    logic [7:0]  r_phase_ticks;
    logic [15:0] r_ack_timeout;

    t_cmd        r_cmd, n_cmd;
    logic [4:0]  r_phase, n_phase;
    logic [7:0]  r_ticks, n_ticks;
    logic [7:0]  r_shift, n_shift;
    logic [15:0] r_wait, n_wait;
    t_lines      r_lines, n_lines;
    logic        r_ack_fail, n_ack_fail;
    logic [7:0]  r_rd_hold, n_rd_hold;

    logic        done;
    logic        rejected;
    logic        jump;
    logic [4:0]  jump_phase;
    logic        fin;
    logic [7:0]  tick_inc;
    logic [7:0]  lim;
    t_phase_out  po;

    // Line levels of phase p of a command; ok low means the command has ended
    function automatic t_phase_out phase_lines(t_cmd cmd, logic [4:0] p, logic b, t_lines cur);
        t_phase_out r;
        r.ok    = 1'b1;
        r.lines = cur;
        unique case (cmd)
            CMD_START: begin
                if (p == 5'd0)      r.lines = '{cur.scl, 1'b1, 1'b1};
                else if (p == 5'd1) r.lines = '{1'b1, 1'b1, 1'b1};
                else if (p == 5'd2) r.lines = '{1'b1, 1'b0, 1'b1};
                else if (p == 5'd3) r.lines = '{1'b0, 1'b0, 1'b1};
                else                r.ok = 1'b0;
            end
            CMD_STOP: begin
                if (p == 5'd0)      r.lines = '{1'b0, 1'b0, 1'b1};
                else if (p == 5'd1) r.lines = '{1'b1, 1'b0, 1'b1};
                else if (p == 5'd2) r.lines = '{1'b1, 1'b1, 1'b1};
                else                r.ok = 1'b0;
            end
            CMD_WR_CHK, CMD_WR: begin
                if (!p[4]) begin
                    r.lines = '{p[0], b, 1'b1};
                end else if (cmd == CMD_WR) begin
                    r.lines = '{1'b0, cur.sda, 1'b1};
                    r.ok    = 1'b0;
                end else if (p == 5'd16 || p == 5'd19) begin
                    r.lines = '{1'b0, 1'b1, 1'b0};
                end else if (p == 5'd17 || p == 5'd18) begin
                    r.lines = '{1'b1, 1'b1, 1'b0};
                end else if (p == 5'd20) begin
                    r.lines = '{1'b0, 1'b0, 1'b1};
                end else if (p == 5'd21) begin
                    r.lines = '{1'b1, 1'b0, 1'b1};
                end else if (p == 5'd22) begin
                    r.lines = '{1'b1, 1'b1, 1'b1};
                end else begin
                    r.ok = 1'b0;
                end
            end
            CMD_RD: begin
                if (!p[4]) r.lines = '{~p[0], 1'b1, 1'b0};
                else       r.ok = 1'b0;
            end
            CMD_ACK: begin
                if (p == 5'd0)                    r.lines = '{1'b0, 1'b1, 1'b1};
                else if (p == 5'd1 || p == 5'd3)  r.lines = '{1'b0, 1'b0, 1'b1};
                else if (p == 5'd2)               r.lines = '{1'b1, 1'b0, 1'b1};
                else begin
                    r.lines = '{1'b0, 1'b1, 1'b1};
                    r.ok    = 1'b0;
                end
            end
            CMD_NACK: begin
                if (p == 5'd0 || p == 5'd2) r.lines = '{1'b0, 1'b1, 1'b1};
                else if (p == 5'd1)         r.lines = '{1'b1, 1'b1, 1'b1};
                else                        r.ok = 1'b0;
            end
            default: r.ok = 1'b0;
        endcase
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= PHASE_TICKS_RST;
            r_ack_timeout <= ACK_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_PHASE_TICKS) begin
                r_phase_ticks <= i_cfg_wdata[7:0];
            end else if (i_cfg_idx == REG_ACK_TIMEOUT) begin
                r_ack_timeout <= i_cfg_wdata;
            end
        end
    end

    assign lim      = (r_phase_ticks == 8'd0) ? 8'd1 : r_phase_ticks;
    assign tick_inc = (r_ticks == 8'hFF) ? 8'hFF : r_ticks + 8'd1;

    // Next state
    always_comb begin
        n_cmd      = r_cmd;
        n_phase    = r_phase;
        n_ticks    = r_ticks;
        n_shift    = r_shift;
        n_wait     = r_wait;
        n_lines    = r_lines;
        n_ack_fail = r_ack_fail;
        n_rd_hold  = r_rd_hold;
        done       = 1'b0;
        rejected   = 1'b0;
        jump       = 1'b0;
        jump_phase = 5'd0;
        fin        = 1'b0;

        if (i_item.op == OP_TICK) begin
            if (r_cmd != CMD_IDLE) begin
                if (r_cmd == CMD_WR_CHK && r_phase == PH_ACK_POLL) begin
                    if (!i_item.sda_in) begin
                        jump       = 1'b1;
                        jump_phase = PH_ACK_END;
                    end else begin
                        n_wait = (r_wait == 16'hFFFF) ? 16'hFFFF : r_wait + 16'd1;
                        if (n_wait >= r_ack_timeout) begin
                            n_ack_fail = 1'b1;
                            jump       = 1'b1;
                            jump_phase = PH_AUTO_STP;
                        end
                    end
                end else if (tick_inc < lim) begin
                    n_ticks = tick_inc;
                end else begin
                    // shift out after SCL high on writes, sample at end of SCL high on reads
                    if ((r_cmd == CMD_WR_CHK || r_cmd == CMD_WR) && !r_phase[4] && r_phase[0]) begin
                        n_shift = {r_shift[6:0], 1'b0};
                    end else if (r_cmd == CMD_RD && !r_phase[4] && !r_phase[0]) begin
                        n_shift = {r_shift[6:0], i_item.sda_in};
                    end
                    if (r_cmd == CMD_WR_CHK && r_phase == PH_ACK_END) begin
                        fin = 1'b1;
                    end else begin
                        jump       = 1'b1;
                        jump_phase = r_phase + 5'd1;
                    end
                end
            end
        end else if (r_cmd != CMD_IDLE) begin
            rejected = 1'b1;
        end else begin
            n_cmd  = t_cmd'(i_item.op + 3'd1);
            n_wait = 16'd0;
            if (i_item.op == OP_WR_CHK || i_item.op == OP_WR) begin
                n_shift    = i_item.wr_data;
                n_ack_fail = 1'b0;
            end else if (i_item.op == OP_RD) begin
                n_shift = 8'd0;
            end
            jump = 1'b1;
        end

        po = phase_lines(n_cmd, jump_phase, n_shift[7], r_lines);
        if (jump) begin
            n_phase = jump_phase;
            n_ticks = 8'd0;
            n_lines = po.lines;
            if (!po.ok) begin
                fin = 1'b1;
            end
        end

        if (fin) begin
            if (n_cmd == CMD_RD) begin
                n_rd_hold = n_shift;
            end
            n_cmd   = CMD_IDLE;
            n_phase = 5'd0;
            n_ticks = 8'd0;
            done    = 1'b1;
        end
    end

    // Result fields
    always_comb begin
        o_result.scl_level    = n_lines.scl;
        o_result.sda_level    = n_lines.drv ? n_lines.sda : 1'b1;
        o_result.sda_drive    = n_lines.drv;
        o_result.busy_res     = (n_cmd != CMD_IDLE);
        o_result.done_res     = done;
        o_result.rd_data      = n_rd_hold;
        o_result.ack_fail     = n_ack_fail;
        o_result.cmd_rejected = rejected;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd      <= CMD_IDLE;
            r_phase    <= 5'd0;
            r_ticks    <= 8'd0;
            r_shift    <= 8'd0;
            r_wait     <= 16'd0;
            r_lines    <= '{1'b1, 1'b1, 1'b1};
            r_ack_fail <= 1'b0;
            r_rd_hold  <= 8'd0;
        end else if (i_step) begin
            r_cmd      <= n_cmd;
            r_phase    <= n_phase;
            r_ticks    <= n_ticks;
            r_shift    <= n_shift;
            r_wait     <= n_wait;
            r_lines    <= n_lines;
            r_ack_fail <= n_ack_fail;
            r_rd_hold  <= n_rd_hold;
        end
    end

endmodule

`default_nettype wire

[rtl/i2cmbe_out_reg.sv]
`default_nettype none

module i2cmbe_out_reg (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    input  i2cmbe_pkg::t_out_item  i_data,
    output logic                   o_advance,
    output logic                   o_out_valid,
    input  wire                    i_out_ready,
    output i2cmbe_pkg::t_out_item  o_out_data
);
    import i2cmbe_pkg::*;

    logic      r_valid;
    t_out_item r_data;

    // stage empties or drains this cycle
    assign o_advance   = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_advance) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_advance) begin
            r_data <= i_data;
        end
    end

endmodule

`default_nettype wire

[rtl/i2c_master_bit_engine.sv]
`default_nettype none
// Stages: input register, core, output register. Throughput: one item per cycle
// while the output accepts results; a single execute stage updates the bit-timing
// state and the result register together.
// Reset: synchronous, active low; idle, SCL high and SDA driven high,
// phase_ticks 10, ack_timeout 100, both pipeline stages empty.

module i2c_master_bit_engine (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_in_valid,
    output logic                               o_in_ready,
    input  i2cmbe_pkg::t_in_item               i_in_data,
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output i2cmbe_pkg::t_out_item              o_out_data,
    input  wire                                i_cfg_we,
    input  wire [i2cmbe_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire [i2cmbe_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);
    import i2cmbe_pkg::*;

    logic      advance;
    logic      stage_valid;
    t_in_item  stage_data;
    t_out_item result;

    i2cmbe_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_advance  (advance),
        .o_valid    (stage_valid),
        .o_data     (stage_data)
    );

    i2cmbe_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_step      (stage_valid && advance),
        .i_item      (stage_data),
        .o_result    (result)
    );

    i2cmbe_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (stage_valid),
        .i_data      (result),
        .o_advance   (advance),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

[verif/tb_i2c_master_bit_engine.sv]
module tb_i2c_master_bit_engine;
    import i2cmbe_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam logic [4:0]  BIT_PHASES  = 5'd16;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in_item              in_beat   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_beat;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    i2c_master_bit_engine i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_beat),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // engine shadow state
    logic [7:0]  cfg_pt    = PHASE_TICKS_RST;
    logic [15:0] cfg_at    = ACK_TIMEOUT_RST;
    t_cmd        cur_cmd   = CMD_IDLE;
    logic [4:0]  ph_idx    = '0;
    logic [7:0]  tick_cnt  = '0;
    logic [7:0]  sh_reg    = '0;
    logic [15:0] poll_cnt  = '0;
    t_lines      bus       = 3'b111;
    logic        nack_seen = 1'b0;
    logic        rejected  = 1'b0;
    logic        finished  = 1'b0;
    logic [7:0]  last_rd   = '0;

    t_in_item  cmd_beats_q[$];
    t_out_item bus_result_q[$];

    bit          src_calm = 1'b0;
    bit          snk_calm = 1'b0;
    int unsigned src_wait = 0;
    int unsigned snk_wait = 0;
    int unsigned cyc      = 0;
    int unsigned pushed   = 0;
    int unsigned n_in     = 0;
    int unsigned n_out    = 0;
    int unsigned n_done   = 0;
    int unsigned n_rej    = 0;
    int unsigned n_nack   = 0;
    int unsigned n_err    = 0;

    function automatic void put_bus(input logic c, input logic d, input logic e);
        bus.scl = c;
        bus.sda = d;
        bus.drv = e;
    endfunction

    // Drives the lines of the current phase; 0 means the command has run out of phases.
    function automatic bit show_phase();
        logic b;
        b = sh_reg[7];
        case (cur_cmd)
            CMD_START: begin
                case (ph_idx)
                    5'd0: put_bus(bus.scl, 1'b1, 1'b1);
                    5'd1: put_bus(1'b1, 1'b1, 1'b1);
                    5'd2: put_bus(1'b1, 1'b0, 1'b1);
                    5'd3: put_bus(1'b0, 1'b0, 1'b1);
                    default: return 1'b0;
                endcase
            end
            CMD_STOP: begin
                case (ph_idx)
                    5'd0: put_bus(1'b0, 1'b0, 1'b1);
                    5'd1: put_bus(1'b1, 1'b0, 1'b1);
                    5'd2: put_bus(1'b1, 1'b1, 1'b1);
                    default: return 1'b0;
                endcase
            end
            CMD_WR_CHK, CMD_WR: begin
                if (ph_idx < BIT_PHASES) begin
                    put_bus(ph_idx[0], b, 1'b1);
                end else if (cur_cmd == CMD_WR) begin
                    put_bus(1'b0, bus.sda, 1'b1);
                    return 1'b0;
                end else begin
                    case (ph_idx)
                        PH_ACK_LOW, PH_ACK_END: put_bus(1'b0, 1'b1, 1'b0);
                        5'd17, PH_ACK_POLL:     put_bus(1'b1, 1'b1, 1'b0);
                        PH_AUTO_STP:            put_bus(1'b0, 1'b0, 1'b1);
                        5'd21:                  put_bus(1'b1, 1'b0, 1'b1);
                        5'd22:                  put_bus(1'b1, 1'b1, 1'b1);
                        default: return 1'b0;
                    endcase
                end
            end
            CMD_RD: begin
                if (ph_idx < BIT_PHASES)
                    put_bus(~ph_idx[0], 1'b1, 1'b0);
                else
                    return 1'b0;
            end
            CMD_ACK: begin
                case (ph_idx)
                    5'd0:       put_bus(1'b0, 1'b1, 1'b1);
                    5'd1, 5'd3: put_bus(1'b0, 1'b0, 1'b1);
                    5'd2:       put_bus(1'b1, 1'b0, 1'b1);
                    default: begin
                        put_bus(1'b0, 1'b1, 1'b1);
                        return 1'b0;
                    end
                endcase
            end
            CMD_NACK: begin
                case (ph_idx)
                    5'd0, 5'd2: put_bus(1'b0, 1'b1, 1'b1);
                    5'd1:       put_bus(1'b1, 1'b1, 1'b1);
                    default: return 1'b0;
                endcase
            end
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic void wrap_up();
        if (cur_cmd == CMD_RD)
            last_rd = sh_reg;
        cur_cmd  = CMD_IDLE;
        ph_idx   = '0;
        tick_cnt = '0;
        finished = 1'b1;
    endfunction

    function automatic void enter_phase(input logic [4:0] p);
        ph_idx   = p;
        tick_cnt = '0;
        if (!show_phase())
            wrap_up();
    endfunction

    function automatic void clock_tick(input logic sda);
        int unsigned lim;
        lim = (cfg_pt == 8'd0) ? 1 : cfg_pt;
        if (cur_cmd == CMD_IDLE)
            return;
        // ack poll counts ticks, not phase time
        if (cur_cmd == CMD_WR_CHK && ph_idx == PH_ACK_POLL) begin
            if (!sda) begin
                enter_phase(PH_ACK_END);
            end else begin
                if (poll_cnt != 16'hFFFF)
                    poll_cnt = poll_cnt + 16'd1;
                if (poll_cnt >= cfg_at) begin
                    nack_seen = 1'b1;
                    n_nack++;
                    enter_phase(PH_AUTO_STP);
                end
            end
            return;
        end
        if (tick_cnt != 8'hFF)
            tick_cnt = tick_cnt + 8'd1;
        if (tick_cnt < lim)
            return;
        if ((cur_cmd == CMD_WR_CHK || cur_cmd == CMD_WR) && ph_idx < BIT_PHASES && ph_idx[0])
            sh_reg = sh_reg << 1;
        else if (cur_cmd == CMD_RD && ph_idx < BIT_PHASES && !ph_idx[0])
            sh_reg = {sh_reg[6:0], sda};
        if (cur_cmd == CMD_WR_CHK && ph_idx == PH_ACK_END) begin
            wrap_up();
            return;
        end
        enter_phase(ph_idx + 5'd1);
    endfunction

    function automatic t_out_item predict_bus_result(input t_in_item it);
        t_out_item  r;
        logic [2:0] nxt;
        rejected = 1'b0;
        finished = 1'b0;
        if (it.op == OP_TICK) begin
            clock_tick(it.sda_in);
        end else if (cur_cmd != CMD_IDLE) begin
            rejected = 1'b1;
        end else begin
            nxt      = it.op + 3'd1;
            cur_cmd  = t_cmd'(nxt);
            poll_cnt = '0;
            if (it.op == OP_WR_CHK || it.op == OP_WR) begin
                sh_reg    = it.wr_data;
                nack_seen = 1'b0;
            end else if (it.op == OP_RD) begin
                sh_reg = '0;
            end
            enter_phase(5'd0);
        end
        r.scl_level    = bus.scl;
        r.sda_level    = bus.drv ? bus.sda : 1'b1;
        r.sda_drive    = bus.drv;
        r.busy_res     = (cur_cmd != CMD_IDLE);
        r.done_res     = finished;
        r.rd_data      = last_rd;
        r.ack_fail     = nack_seen;
        r.cmd_rejected = rejected;
        return r;
    endfunction

    function automatic int unsigned draw_idle(input bit calm);
        return calm ? 0 : $urandom_range(0, 19);
    endfunction

    task automatic flag_error(input string msg);
        if (n_err < 100)
            $display("[cycle %0d] result %0d: %s", cyc, n_out, msg);
        n_err++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            flag_error($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    always @(posedge clk) begin
        cyc <= cyc + 1;
        if (cyc > CYCLE_LIMIT) begin
            $display("timeout: %0d beats still queued, %0d results outstanding",
                     cmd_beats_q.size(), bus_result_q.size());
            $display("tb_i2c_master_bit_engine: done, errors");
            $finish;
        end
    end

    always @(posedge clk) begin : driver
        bit slot_free;
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_beat  <= '0;
            src_wait <= 0;
        end else begin
            slot_free = !in_valid;
            if (in_valid && in_ready) begin
                bus_result_q.push_back(predict_bus_result(in_beat));
                n_in++;
                slot_free = 1'b1;
            end
            if (slot_free) begin
                if (src_wait != 0) begin
                    src_wait <= src_wait - 1;
                    in_valid <= 1'b0;
                end else if (cmd_beats_q.size() != 0) begin
                    in_beat  <= cmd_beats_q.pop_front();
                    in_valid <= 1'b1;
                    src_wait <= draw_idle(src_calm);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin : monitor
        t_out_item   want;
        int unsigned n;
        if (!rst_n) begin
            out_ready <= 1'b0;
            snk_wait  <= 0;
        end else if (out_valid && out_ready) begin
            if (bus_result_q.size() == 0) begin
                flag_error("result beat with nothing expected");
            end else begin
                want = bus_result_q.pop_front();
                check_field("scl_level", 8'(out_beat.scl_level), 8'(want.scl_level));
                check_field("sda_level", 8'(out_beat.sda_level), 8'(want.sda_level));
                check_field("sda_drive", 8'(out_beat.sda_drive), 8'(want.sda_drive));
                check_field("busy_res", 8'(out_beat.busy_res), 8'(want.busy_res));
                check_field("done_res", 8'(out_beat.done_res), 8'(want.done_res));
                check_field("rd_data", out_beat.rd_data, want.rd_data);
                check_field("ack_fail", 8'(out_beat.ack_fail), 8'(want.ack_fail));
                check_field("cmd_rejected", 8'(out_beat.cmd_rejected),
                            8'(want.cmd_rejected));
                if (want.done_res)
                    n_done++;
                if (want.cmd_rejected)
                    n_rej++;
            end
            n_out++;
            n = draw_idle(snk_calm);
            snk_wait  <= n;
            out_ready <= (n == 0);
        end else if (snk_wait != 0) begin
            snk_wait  <= snk_wait - 1;
            out_ready <= (snk_wait == 1);
        end else begin
            out_ready <= 1'b1;
        end
    end

    function automatic int unsigned lim_now();
        return (cfg_pt == 8'd0) ? 1 : cfg_pt;
    endfunction

    task automatic push_beat(input t_op op, input logic [7:0] data, input logic sda);
        t_in_item it;
        it.op      = op;
        it.wr_data = data;
        it.sda_in  = sda;
        cmd_beats_q.push_back(it);
        pushed++;
    endtask

    task automatic push_tick(input logic sda);
        push_beat(OP_TICK, 8'($urandom_range(0, 255)), sda);
    endtask

    // One command with the ticks it needs; a broken one stops short.
    task automatic run_seq(input t_op op, input bit broken, input bit want_fail);
        int unsigned lim;
        int unsigned total;
        int unsigned k;
        bit          give_up;
        lim = lim_now();
        push_beat(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        case (op)
            OP_START, OP_ACK: total = 4 * lim;
            OP_STOP, OP_NACK: total = 3 * lim;
            OP_WR, OP_RD:     total = 16 * lim;
            default:          total = 18 * lim;
        endcase
        if (broken)
            total = $urandom_range(0, total - 1);
        for (int unsigned i = 0; i < total; i++) begin
            if ($urandom_range(0, 39) == 0)
                push_beat(t_op'($urandom_range(0, 6)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
            push_tick(1'($urandom_range(0, 1)));
        end
        if (broken || op != OP_WR_CHK)
            return;
        give_up = want_fail || (cfg_at <= 16'd64 && $urandom_range(0, 2) == 0);
        if (give_up) begin
            repeat ((cfg_at == 16'd0) ? 1 : cfg_at) push_tick(1'b1);
            repeat (3 * lim) push_tick(1'($urandom_range(0, 1)));
        end else begin
            k = (cfg_at == 16'd0) ? 0 : $urandom_range(0, (cfg_at > 7) ? 6 : cfg_at - 1);
            repeat (k) push_tick(1'b1);
            push_tick(1'b0);
            repeat (lim) push_tick(1'($urandom_range(0, 1)));
        end
    endtask

    task automatic random_phase(input int unsigned budget);
        int unsigned stop_at;
        int unsigned r;
        stop_at = pushed + budget;
        while (pushed < stop_at) begin
            r = $urandom_range(0, 9);
            if (r < 7)
                run_seq(t_op'($urandom_range(0, 6)), 1'b0, 1'b0);
            else if (r < 9)
                run_seq(t_op'($urandom_range(0, 6)), 1'b1, 1'b0);
            else
                repeat ($urandom_range(1, 4))
                    push_beat(t_op'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
        end
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (cmd_beats_q.size() != 0 || in_valid || bus_result_q.size() != 0);
    endtask

    // Finish whatever command is still open, then let the pipeline empty.
    task automatic settle_idle();
        drain();
        while (cur_cmd != CMD_IDLE) begin
            repeat (lim_now()) push_tick(1'b0);
            drain();
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic config_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_PHASE_TICKS)
            cfg_pt = val[7:0];
        else if (idx == REG_ACK_TIMEOUT)
            cfg_at = val;
    endtask

    task automatic apply_setting(input logic [7:0] pt, input logic [15:0] at,
                                 input bit quiet_src, input bit quiet_snk);
        logic [7:0] junk;
        junk = 8'($urandom_range(0, 255));
        config_write(REG_PHASE_TICKS, {junk, pt});
        config_write(REG_ACK_TIMEOUT, at);
        src_calm = quiet_src;
        snk_calm = quiet_snk;
    endtask

    initial begin : stimulus
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: idle ticks, then a start with every command thrown at it
        push_beat(OP_TICK, 8'h00, 1'b0);
        push_beat(OP_TICK, 8'hFF, 1'b1);
        push_beat(OP_START, 8'hFF, 1'b1);
        push_beat(OP_STOP, 8'h00, 1'b0);
        push_beat(OP_WR_CHK, 8'hFF, 1'b1);
        push_beat(OP_WR, 8'h00, 1'b0);
        push_beat(OP_RD, 8'hA5, 1'b1);
        push_beat(OP_ACK, 8'h5A, 1'b0);
        push_beat(OP_NACK, 8'hFF, 1'b1);
        for (int i = 0; i < 16; i++)
            push_beat(OP_TICK, 8'h00, i[0]);
        settle_idle();
        run_seq(OP_WR_CHK, 1'b0, 1'b1);
        run_seq(OP_STOP, 1'b0, 1'b0);
        settle_idle();

        // zero phase time and zero ack timeout
        apply_setting(8'd0, 16'd0, 1'b0, 1'b1);
        run_seq(OP_RD, 1'b0, 1'b0);
        run_seq(OP_WR_CHK, 1'b0, 1'b1);
        random_phase(120);
        settle_idle();

        apply_setting(8'd1, 16'd1, 1'b1, 1'b1);
        random_phase(200);
        settle_idle();

        apply_setting(8'd2, 16'hFFFF, 1'b0, 1'b0);
        random_phase(200);
        settle_idle();

        apply_setting(8'd1, 16'd5, 1'b0, 1'b1);
        random_phase(200);
        settle_idle();

        apply_setting(8'd3, 16'd3, 1'b1, 1'b0);
        random_phase(170);
        settle_idle();

        // longest phase time: only the first phase boundary is walked
        apply_setting(8'd255, 16'hFFFF, 1'b0, 1'b0);
        push_beat(OP_WR_CHK, 8'h80, 1'b0);
        for (int i = 0; i < 300; i++) begin
            if ($urandom_range(0, 19) == 0)
                push_beat(t_op'($urandom_range(0, 6)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
            push_tick(1'($urandom_range(0, 1)));
        end
        drain();
        repeat (8) @(posedge clk);

        $display("covered %0d input beats, %0d results checked, %0d errors",
                 n_in, n_out, n_err);
        $display("commands completed %0d, rejected %0d, missing acks %0d",
                 n_done, n_rej, n_nack);
        if (n_err == 0 && bus_result_q.size() == 0)
            $display("tb_i2c_master_bit_engine: done, clean");
        else
            $display("tb_i2c_master_bit_engine: done, errors");
        $finish;
    end

endmodule
